// File: rtl/c2s_pkg.sv
// Shared types, codes and constants of the cloud to scan range fuse block.
package c2s_pkg;

  typedef enum logic [1:0] {
    MODE_SCAN  = 2'd0,
    MODE_START = 2'd1,
    MODE_POINT = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_Z_MIN       = 3'd0,
    REG_Z_MAX       = 3'd1,
    REG_INIT_RANGE  = 3'd2,
    REG_ANGLE_START = 3'd3,
    REG_ANGLE_STEP  = 3'd4,
    REG_YAW_OFFSET  = 3'd5,
    REG_FIRST_INDEX = 3'd6,
    REG_NUM_BINS    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ,
    F_CORD,
    F_ANG,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPD,
    B_RD,
    B_SWEEP
  } back_state_e;

  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 16;
  localparam int DIV_STEPS    = 19;
  localparam int Q_DEPTH      = 2;
  localparam logic signed [22:0] PI_Q20 = 23'sd3294199;
  localparam logic [17:0] DIST_PAD = 18'd50;

  typedef struct packed {
    logic signed [15:0] z_min;
    logic signed [15:0] z_max;
    logic [15:0]        init_range;
    logic signed [15:0] angle_start;
    logic [13:0]        angle_step;
    logic signed [15:0] yaw_offset;
    logic [11:0]        first_index;
    logic [10:0]        num_bins;
  } cfg_t;

  typedef struct packed {
    logic        fill;
    logic        scan_wr;
    logic        cloud_upd;
    logic        rd;
    logic        bin_ok;
    logic [11:0] addr;
    logic [15:0] data;
    logic [15:0] fill_val;
    logic [9:0]  bin_index;
  } op_t;

  function automatic logic [19:0] atan_q20(input logic [4:0] i);
    logic [19:0] v;
    case (i)
      5'd0:  v = 20'd823550;
      5'd1:  v = 20'd486170;
      5'd2:  v = 20'd256879;
      5'd3:  v = 20'd130396;
      5'd4:  v = 20'd65451;
      5'd5:  v = 20'd32757;
      5'd6:  v = 20'd16383;
      5'd7:  v = 20'd8192;
      5'd8:  v = 20'd4096;
      5'd9:  v = 20'd2048;
      5'd10: v = 20'd1024;
      5'd11: v = 20'd512;
      5'd12: v = 20'd256;
      5'd13: v = 20'd128;
      5'd14: v = 20'd64;
      5'd15: v = 20'd32;
      5'd16: v = 20'd16;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/c2s_ram.sv
// Generic single write port RAM with registered read.
module c2s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/c2s_front.sv
// Front end: accepts items, classifies them and computes point bin and distance.
module c2s_front #(
  parameter int MAX_BINS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c2s_pkg::cfg_t       cfg_i,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode_i,
  input  logic [11:0]         sample_index_i,
  input  logic [15:0]         range_mm_i,
  input  logic signed [15:0]  point_x_i,
  input  logic signed [15:0]  point_y_i,
  input  logic signed [15:0]  point_z_i,
  input  logic                point_valid_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output c2s_pkg::op_t        q_data_o
);

  c2s_pkg::front_state_e state_q, state_d;
  logic               seen_q;
  logic [4:0]         cnt_q, cnt_d;
  logic [30:0]        xx_q, yy_q;
  logic signed [34:0] cx_q, cy_q, cx_d, cy_d;
  logic signed [22:0] z_q, z_d;
  logic               xneg_q, yneg_q, orig_q;
  logic signed [16:0] off_q;
  logic [13:0]        step_q;
  logic [12:0]        nb_q;
  logic [31:0]        r_q, rem_q, bit_q, r_d, rem_d, bit_d;
  logic [18:0]        dvd_q, dvd_d;
  logic [13:0]        drem_q, drem_d;
  logic               neg_q;
  logic [15:0]        dist_q;

  logic        accept;
  logic [12:0] nb;
  logic [11:0] idx_off;
  logic        win, take, direct;
  logic [16:0] ax, ay;
  c2s_pkg::op_t op;
  logic signed [34:0] dx, dy;
  logic [31:0] trial;
  logic signed [22:0] zm, zs;
  logic signed [25:0] num, amag;
  logic [16:0] rr;
  logic [17:0] dsum;
  logic [14:0] dtrial;
  logic        ok;

  assign nb = ({2'b0, cfg_i.num_bins} > 13'(MAX_BINS)) ? 13'(MAX_BINS)
                                                       : {2'b0, cfg_i.num_bins};
  assign full   = (state_q != c2s_pkg::F_IDLE) || q_full_i;
  assign accept = push && !full;
  assign idx_off = sample_index_i - cfg_i.first_index;
  assign win = (sample_index_i >= cfg_i.first_index) && ({1'b0, idx_off} < nb);
  assign take = seen_q && point_valid_i && (point_z_i >= cfg_i.z_min)
                && (point_z_i <= cfg_i.z_max);
  assign ax = point_x_i[15] ? -{point_x_i[15], point_x_i} : {point_x_i[15], point_x_i};
  assign ay = point_y_i[15] ? -{point_y_i[15], point_y_i} : {point_y_i[15], point_y_i};
  assign ok = (!neg_q || (dvd_q == '0)) && (dvd_q < 19'(nb_q));

  always_comb begin
    op = '0;
    direct = 1'b0;
    case (c2s_pkg::mode_e'(mode_i))
      c2s_pkg::MODE_SCAN: begin
        op.fill     = !seen_q;
        op.fill_val = cfg_i.init_range;
        op.scan_wr  = win;
        op.addr     = idx_off;
        op.data     = range_mm_i;
        direct      = !seen_q || win;
      end
      c2s_pkg::MODE_START: begin
        op.fill     = 1'b1;
        op.fill_val = cfg_i.init_range;
        direct      = seen_q;
      end
      c2s_pkg::MODE_READ: begin
        op.rd        = 1'b1;
        op.bin_ok    = {1'b0, sample_index_i} < nb;
        op.addr      = sample_index_i;
        op.bin_index = sample_index_i[9:0];
        direct       = 1'b1;
      end
      default: begin
        direct = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c2s_pkg::F_IDLE: begin
        if (accept && (c2s_pkg::mode_e'(mode_i) == c2s_pkg::MODE_POINT) && take) begin
          state_d = c2s_pkg::F_SQ;
        end
      end
      c2s_pkg::F_SQ:   state_d = c2s_pkg::F_CORD;
      c2s_pkg::F_CORD: begin
        if (cnt_q == 5'(c2s_pkg::CORDIC_STEPS - 1)) begin
          state_d = c2s_pkg::F_ANG;
        end
      end
      c2s_pkg::F_ANG:  state_d = c2s_pkg::F_DIV;
      c2s_pkg::F_DIV: begin
        if (cnt_q == 5'(c2s_pkg::DIV_STEPS - 1)) begin
          state_d = c2s_pkg::F_PUSH;
        end
      end
      c2s_pkg::F_PUSH: begin
        if (!ok || !q_full_i) begin
          state_d = c2s_pkg::F_IDLE;
        end
      end
      default: state_d = c2s_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    q_push_o = 1'b0;
    q_data_o = op;
    unique case (state_q)
      c2s_pkg::F_IDLE: q_push_o = accept && direct;
      c2s_pkg::F_PUSH: begin
        q_push_o          = ok && !q_full_i;
        q_data_o          = '0;
        q_data_o.cloud_upd = 1'b1;
        q_data_o.addr     = dvd_q[11:0];
        q_data_o.data     = dist_q;
      end
      default: q_push_o = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q + 5'd1;
    if ((state_q == c2s_pkg::F_SQ) || (state_q == c2s_pkg::F_ANG)) begin
      cnt_d = '0;
    end
    dx = cy_q >>> cnt_q;
    dy = cx_q >>> cnt_q;
    if (cy_q >= 0) begin
      cx_d = cx_q + dx;
      cy_d = cy_q - dy;
      z_d  = z_q + $signed({3'b0, c2s_pkg::atan_q20(cnt_q)});
    end else begin
      cx_d = cx_q - dx;
      cy_d = cy_q + dy;
      z_d  = z_q - $signed({3'b0, c2s_pkg::atan_q20(cnt_q)});
    end
    trial = r_q + bit_q;
    r_d   = r_q;
    rem_d = rem_q;
    bit_d = bit_q;
    if (cnt_q < 5'(c2s_pkg::SQRT_STEPS)) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        r_d   = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
    zm   = orig_q ? 23'sd0 : (xneg_q ? c2s_pkg::PI_Q20 - z_q : z_q);
    zs   = yneg_q ? -zm : zm;
    num  = {{3{zs[22]}}, zs} - {{2{off_q[16]}}, off_q, 7'b0};
    amag = num[25] ? -num : num;
    rr   = r_q[16:0] + 17'(rem_q > r_q);
    dsum = {1'b0, rr} + c2s_pkg::DIST_PAD;
    dtrial = {drem_q, dvd_q[18]};
    if (dtrial >= {1'b0, step_q}) begin
      drem_d = 14'(dtrial - {1'b0, step_q});
      dvd_d  = {dvd_q[17:0], 1'b1};
    end else begin
      drem_d = dtrial[13:0];
      dvd_d  = {dvd_q[17:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c2s_pkg::F_IDLE;
      seen_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept && (c2s_pkg::mode_e'(mode_i) == c2s_pkg::MODE_SCAN)) begin
        seen_q <= 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      c2s_pkg::F_IDLE: begin
        xx_q   <= 31'(point_x_i * point_x_i);
        yy_q   <= 31'(point_y_i * point_y_i);
        cx_q   <= $signed({2'b0, ax, 16'b0});
        cy_q   <= $signed({2'b0, ay, 16'b0});
        xneg_q <= point_x_i[15];
        yneg_q <= point_y_i[15];
        orig_q <= (point_x_i == '0) && (point_y_i == '0);
        off_q  <= $signed({cfg_i.angle_start[15], cfg_i.angle_start})
                  + $signed({cfg_i.yaw_offset[15], cfg_i.yaw_offset});
        step_q <= (cfg_i.angle_step == '0) ? 14'd1 : cfg_i.angle_step;
        nb_q   <= nb;
      end
      c2s_pkg::F_SQ: begin
        rem_q <= {1'b0, xx_q} + {1'b0, yy_q};
        r_q   <= '0;
        bit_q <= 32'h4000_0000;
        z_q   <= '0;
      end
      c2s_pkg::F_CORD: begin
        cx_q  <= cx_d;
        cy_q  <= cy_d;
        z_q   <= z_d;
        r_q   <= r_d;
        rem_q <= rem_d;
        bit_q <= bit_d;
      end
      c2s_pkg::F_ANG: begin
        neg_q  <= num[25];
        dvd_q  <= amag[25:7];
        drem_q <= '0;
        dist_q <= (dsum[17:16] != 2'b0) ? 16'hFFFF : dsum[15:0];
      end
      c2s_pkg::F_DIV: begin
        dvd_q  <= dvd_d;
        drem_q <= drem_d;
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

endmodule

// File: rtl/c2s_fifo.sv
// Short operation queue between front and back ends.
module c2s_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  c2s_pkg::op_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output c2s_pkg::op_t data_o,
  output logic         empty_o
);

  localparam int PW = $clog2(c2s_pkg::Q_DEPTH);
  localparam int CW = $clog2(c2s_pkg::Q_DEPTH + 1);

  c2s_pkg::op_t    mem_q [c2s_pkg::Q_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CW'(c2s_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(c2s_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(c2s_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/c2s_back.sv
// Back end: executes queued operations on the scan and cloud bin memories.
module c2s_back #(
  parameter int MAX_BINS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_empty_i,
  input  c2s_pkg::op_t q_data_i,
  output logic         q_pop_o,
  output logic         empty,
  input  logic         pop,
  output logic [9:0]   bin_index_o,
  output logic [15:0]  fused_range_o,
  output logic         bin_ok_o
);

  localparam int AW = $clog2(MAX_BINS);

  c2s_pkg::back_state_e state_q, state_d;
  logic [AW-1:0] cnt_q;
  logic [AW-1:0] upd_addr_q;
  logic [15:0]   upd_data_q, fill_val_q;
  logic          rd_ok_q;
  logic [9:0]    rd_idx_q;
  logic          out_valid_q;
  logic [9:0]    out_idx_q;
  logic [15:0]   out_range_q;
  logic          out_ok_q;

  logic          can_take;
  logic          scan_we, cloud_we;
  logic [AW-1:0] cloud_waddr;
  logic [15:0]   cloud_wdata, scan_rdata, cloud_rdata;

  assign can_take = !q_empty_i && (!q_data_i.rd || !out_valid_q);

  c2s_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_scan_ram (
    .clk_i   (clk_i),
    .we_i    (scan_we),
    .waddr_i (q_data_i.addr[AW-1:0]),
    .wdata_i (q_data_i.data),
    .raddr_i (q_data_i.addr[AW-1:0]),
    .rdata_o (scan_rdata)
  );

  c2s_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_cloud_ram (
    .clk_i   (clk_i),
    .we_i    (cloud_we),
    .waddr_i (cloud_waddr),
    .wdata_i (cloud_wdata),
    .raddr_i (q_data_i.addr[AW-1:0]),
    .rdata_o (cloud_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c2s_pkg::B_IDLE: begin
        if (can_take) begin
          if (q_data_i.fill) begin
            state_d = c2s_pkg::B_SWEEP;
          end else if (q_data_i.cloud_upd) begin
            state_d = c2s_pkg::B_UPD;
          end else if (q_data_i.rd) begin
            state_d = c2s_pkg::B_RD;
          end
        end
      end
      c2s_pkg::B_UPD: state_d = c2s_pkg::B_IDLE;
      c2s_pkg::B_RD:  state_d = c2s_pkg::B_IDLE;
      c2s_pkg::B_SWEEP: begin
        if (cnt_q == AW'(MAX_BINS - 1)) begin
          state_d = c2s_pkg::B_IDLE;
        end
      end
      default: state_d = c2s_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    scan_we     = 1'b0;
    cloud_we    = 1'b0;
    cloud_waddr = upd_addr_q;
    cloud_wdata = upd_data_q;
    unique case (state_q)
      c2s_pkg::B_IDLE: begin
        q_pop_o = can_take;
        scan_we = can_take && q_data_i.scan_wr;
      end
      c2s_pkg::B_UPD: cloud_we = upd_data_q < cloud_rdata;
      c2s_pkg::B_SWEEP: begin
        cloud_we    = 1'b1;
        cloud_waddr = cnt_q;
        cloud_wdata = fill_val_q;
      end
      default: cloud_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= c2s_pkg::B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == c2s_pkg::B_SWEEP) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == c2s_pkg::B_RD) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == c2s_pkg::B_IDLE) begin
      upd_addr_q <= q_data_i.addr[AW-1:0];
      upd_data_q <= q_data_i.data;
      fill_val_q <= q_data_i.fill_val;
      rd_ok_q    <= q_data_i.bin_ok;
      rd_idx_q   <= q_data_i.bin_index;
    end
    if (state_q == c2s_pkg::B_RD) begin
      out_idx_q   <= rd_idx_q;
      out_ok_q    <= rd_ok_q;
      out_range_q <= !rd_ok_q ? 16'd0
                   : (scan_rdata < cloud_rdata) ? scan_rdata : cloud_rdata;
    end
  end

  assign empty         = !out_valid_q;
  assign bin_index_o   = out_idx_q;
  assign fused_range_o = out_range_q;
  assign bin_ok_o      = out_ok_q;

endmodule

// File: rtl/cloud_to_scan_min_range_fuse.sv
// Top level of the cloud to scan range fuse block: registers, front, queue, back.
//
//   channel   signals                               transaction when
//   input     push, full, mode_i .. point_valid_i   push && !full
//   result    empty, pop, bin_index_o .. bin_ok_o   pop && !empty
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i      cfg_we_i
//
// Scan samples, starts and reads go to the queue in the cycle they are accepted; a point
// holds the front end full through setup, 20 CORDIC steps, angle, 19 divider steps, push.
// A cloud fill (first scan sample, or a start after it) sweeps all MAX_BINS cloud bins.
// Reads and point updates go through B_RD or B_UPD in the back end (registered RAM read).
// A full queue stalls the front end; a waiting result stalls only back end reads.
// Reset loads register defaults and empties front, queue and back; bin memories hold no reset.
module cloud_to_scan_min_range_fuse #(
  parameter int MAX_BINS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         mode_i,
  input  logic [11:0]        sample_index_i,
  input  logic [15:0]        range_mm_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic               point_valid_i,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         bin_index_o,
  output logic [15:0]        fused_range_o,
  output logic               bin_ok_o
);

  c2s_pkg::cfg_t cfg_q;
  c2s_pkg::op_t  f_op, q_op;
  logic          q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.z_min       <= 16'sd100;
      cfg_q.z_max       <= 16'sd1000;
      cfg_q.init_range  <= 16'd4000;
      cfg_q.angle_start <= -16'sd15974;
      cfg_q.angle_step  <= 14'd36;
      cfg_q.yaw_offset  <= 16'sd0;
      cfg_q.first_index <= 12'd0;
      cfg_q.num_bins    <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (c2s_pkg::reg_e'(cfg_idx_i))
        c2s_pkg::REG_Z_MIN:       cfg_q.z_min       <= $signed(cfg_wdata_i);
        c2s_pkg::REG_Z_MAX:       cfg_q.z_max       <= $signed(cfg_wdata_i);
        c2s_pkg::REG_INIT_RANGE:  cfg_q.init_range  <= cfg_wdata_i;
        c2s_pkg::REG_ANGLE_START: cfg_q.angle_start <= $signed(cfg_wdata_i);
        c2s_pkg::REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_wdata_i[13:0];
        c2s_pkg::REG_YAW_OFFSET:  cfg_q.yaw_offset  <= $signed(cfg_wdata_i);
        c2s_pkg::REG_FIRST_INDEX: cfg_q.first_index <= cfg_wdata_i[11:0];
        c2s_pkg::REG_NUM_BINS:    cfg_q.num_bins    <= cfg_wdata_i[10:0];
        default:                  cfg_q             <= cfg_q;
      endcase
    end
  end

  c2s_front #(.MAX_BINS(MAX_BINS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .sample_index_i (sample_index_i),
    .range_mm_i     (range_mm_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .point_valid_i  (point_valid_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (f_op)
  );

  c2s_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (f_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_op),
    .empty_o (q_empty)
  );

  c2s_back #(.MAX_BINS(MAX_BINS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_op),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .bin_index_o   (bin_index_o),
    .fused_range_o (fused_range_o),
    .bin_ok_o      (bin_ok_o)
  );

endmodule

// File: rtl/c2s_checker.sv
// Port level checks of the cloud to scan range fuse block and their binding.
module c2s_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [9:0]  bin_index_o,
  input logic [15:0] fused_range_o,
  input logic        bin_ok_o
);

  a_bad_bin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !bin_ok_o) |-> (fused_range_o == 16'd0))
    else $error("out of range bin with nonzero range");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(bin_index_o) && $stable(fused_range_o)
                          && $stable(bin_ok_o)))
    else $error("waiting result changed");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result present after reset");

endmodule

bind cloud_to_scan_min_range_fuse c2s_checker u_c2s_checker (.*);
